### rtl/brsc_pkg.sv
`timescale 1ns / 1ps
package brsc_pkg;

  localparam int unsigned DelayW   = 8;
  localparam int unsigned SpacingW = 11;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned DistW    = 13;
  localparam int unsigned ErrW     = 10;

  // square lanes: pair-index squares and the spacing square, one bit a cycle
  localparam int unsigned SqSteps  = SpacingW;
  localparam int unsigned SqCntW   = $clog2(SqSteps);
  localparam int unsigned PairSqW  = 2 * DelayW + 1;
  localparam int unsigned SpSqW    = 2 * SpacingW;
  localparam int unsigned PartW    = 2 * DelayW - 1;

  // radicand and root, two radicand bits per root bit
  localparam int unsigned RadW     = 30;
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned RootCntW = $clog2(RootW);
  localparam int unsigned RemW     = RootW + 3;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [1:0] {
    REG_SPACING   = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQ   = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [SpacingW-1:0] spacing;
    logic [LimitW-1:0]   limit;
    logic [DistW-1:0]    threshold;
  } cfg_t;

  typedef struct packed {
    logic            done;
    logic            neg;
    logic [RadW-1:0] rad;
  } sq_res_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } root_res_t;

  // correction toward zero by distance band
  function automatic logic [3:0] band_step(input logic [DistW-1:0] d);
    logic [3:0] s;
    if (d >= DistW'(920))      s = 4'd2;
    else if (d >= DistW'(860)) s = 4'd3;
    else if (d >= DistW'(740)) s = 4'd4;
    else if (d >= DistW'(590)) s = 4'd5;
    else if (d >= DistW'(230)) s = 4'd6;
    else if (d >= DistW'(60))  s = 4'd7;
    else                       s = 4'd8;
    return s;
  endfunction

endpackage

### rtl/brsc_if.sv
`timescale 1ns / 1ps
interface brsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] delay_front_left;
  logic [7:0] delay_front_right;
  logic [7:0] delay_back_right;
  logic [7:0] delay_back_left;

  modport source (
    output valid, delay_front_left, delay_front_right, delay_back_right, delay_back_left,
    input  ready
  );
  modport sink (
    input  valid, delay_front_left, delay_front_right, delay_back_right, delay_back_left,
    output ready
  );
endinterface

interface brsc_out_if;
  logic              valid;
  logic              ready;
  logic              stopped;
  logic              heading_front;
  logic [12:0]       distance_tenths;
  logic signed [9:0] steer_error;
  logic              distance_invalid;

  modport source (
    output valid, stopped, heading_front, distance_tenths, steer_error, distance_invalid,
    input  ready
  );
  modport sink (
    input  valid, stopped, heading_front, distance_tenths, steer_error, distance_invalid,
    output ready
  );
endinterface

### rtl/brsc_cfg.sv
`timescale 1ns / 1ps
module brsc_cfg
  import brsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SPACING:   cfg_d.spacing   = pwdata[SpacingW-1:0];
        REG_LIMIT:     cfg_d.limit     = pwdata[LimitW-1:0];
        REG_THRESHOLD: cfg_d.threshold = pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPACING:   prdata = {{(32-SpacingW){1'b0}}, cfg_q.spacing};
      REG_LIMIT:     prdata = {{(32-LimitW){1'b0}}, cfg_q.limit};
      REG_THRESHOLD: prdata = {{(32-DistW){1'b0}}, cfg_q.threshold};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacing   <= SpacingW'(200);
      cfg_q.limit     <= LimitW'(50);
      cfg_q.threshold <= DistW'(1000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/brsc_sqr.sv
`timescale 1ns / 1ps
module brsc_sqr
  import brsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DelayW-1:0]   idx1_i,
  input  logic [DelayW-1:0]   idx2_i,
  input  logic [SpacingW-1:0] spacing_i,
  output sq_res_t             res_o
);

  logic                busy_q, fin_q, done_q;
  logic [SqCntW-1:0]   cnt_q;
  logic [DelayW-1:0]   m1_q, m2_q;
  logic [PartW-1:0]    md1_q, md2_q;
  logic [SpacingW-1:0] ms_q;
  logic [SpSqW-1:0]    mds_q;
  logic [PairSqW-1:0]  q_q, q_d;
  logic [SpSqW-1:0]    s2_q, s2_d;
  logic [RadW-1:0]     rad_q;
  logic                neg_q;

  logic [RadW-1:0]     scaled;
  logic [RadW:0]       diff;

  // one multiplier bit per cycle on each lane
  always_comb begin
    q_d  = q_q + (m1_q[0] ? PairSqW'(md1_q) : '0) + (m2_q[0] ? PairSqW'(md2_q) : '0);
    s2_d = s2_q + (ms_q[0] ? mds_q : '0);
  end

  // 2*(34*i)^2 = 2312*i^2, and 2312 = 2048 + 256 + 8
  assign scaled = RadW'({q_q, 11'b0}) + RadW'({q_q, 8'b0}) + RadW'({q_q, 3'b0});
  assign diff   = {1'b0, scaled} - (RadW+1)'(s2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SqCntW'(SqSteps - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m1_q  <= idx1_i;
      m2_q  <= idx2_i;
      md1_q <= PartW'(idx1_i);
      md2_q <= PartW'(idx2_i);
      ms_q  <= spacing_i;
      mds_q <= SpSqW'(spacing_i);
      q_q   <= '0;
      s2_q  <= '0;
    end else if (busy_q) begin
      m1_q  <= m1_q >> 1;
      m2_q  <= m2_q >> 1;
      md1_q <= md1_q << 1;
      md2_q <= md2_q << 1;
      ms_q  <= ms_q >> 1;
      mds_q <= mds_q << 1;
      q_q   <= q_d;
      s2_q  <= s2_d;
    end
    if (fin_q) begin
      rad_q <= diff[RadW-1:0];
      neg_q <= diff[RadW];
    end
  end

  assign res_o.done = done_q;
  assign res_o.neg  = neg_q;
  assign res_o.rad  = rad_q;

endmodule

### rtl/brsc_isqrt.sv
`timescale 1ns / 1ps
module brsc_isqrt
  import brsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RadW-1:0] rad_i,
  output root_res_t       res_o
);

  logic                busy_q, done_q;
  logic [RootCntW-1:0] cnt_q;
  logic [RadW-1:0]     v_q;
  logic [RemW-1:0]     rem_q, rem_sh, trial;
  logic [RootW-1:0]    root_q;
  logic                fits;

  // bring down the next bit pair and try 4*root + 1
  assign rem_sh = {rem_q[RemW-3:0], v_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == RootCntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[RadW-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.root = root_q;

endmodule

### rtl/beacon_range_steer_calc.sv
`timescale 1ns / 1ps
// A located beacon passes through the bit-serial square unit, then the root unit,
// then the finishing state; a negative radicand skips the root unit, and an item
// with all four delays zero goes straight to the finishing state.
// One item at a time: input is ready only in the idle state, after the last
// result is loaded for output. Reset is asynchronous, active low: held heading
// is front, held distance and error zero, no result pending.
module beacon_range_steer_calc
  import brsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  brsc_in_if.sink     in_i,
  brsc_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e    state_q, state_d;
  cfg_t      cfg;
  sq_res_t   sq_res;
  root_res_t root_res;

  logic              in_acc, in_stop, in_front;
  logic [DelayW-1:0] idx1, idx2;
  logic              sq_start, root_start, out_load;

  logic [DelayW-1:0] fl_q, fr_q, br_q, bl_q;
  logic              stop_q, front_q, neg_q;

  logic                    out_valid_q;
  logic                    out_stop_q, out_front_q, out_inv_q;
  logic [DistW-1:0]        out_dist_q;
  logic signed [ErrW-1:0]  out_err_q;

  logic                    held_front_q, held_inv_q;
  logic [DistW-1:0]        held_dist_q;
  logic signed [ErrW-1:0]  held_err_q;

  logic [DistW-1:0]        new_dist;
  logic signed [ErrW-1:0]  pair_err, lim_s, clamp_err, new_err;
  logic [DelayW:0]         sum_rb, sum_lb;
  logic signed [DelayW+2:0] diag, near_err, near_adj;
  logic [3:0]              step;
  logic                    near;

  brsc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  assign in_acc   = in_i.valid & in_i.ready;
  assign in_stop  = (in_i.delay_front_left == '0) && (in_i.delay_front_right == '0) &&
                    (in_i.delay_back_right == '0) && (in_i.delay_back_left == '0);
  assign in_front = ({1'b0, in_i.delay_front_left} + {1'b0, in_i.delay_front_right}) <=
                    ({1'b0, in_i.delay_back_right} + {1'b0, in_i.delay_back_left});
  assign idx1     = in_front ? in_i.delay_front_left  : in_i.delay_back_right;
  assign idx2     = in_front ? in_i.delay_front_right : in_i.delay_back_left;
  assign sq_start = in_acc & ~in_stop;

  brsc_sqr u_sqr (
    .clk_i, .rst_ni,
    .start_i   (sq_start),
    .idx1_i    (idx1),
    .idx2_i    (idx2),
    .spacing_i (cfg.spacing),
    .res_o     (sq_res)
  );

  assign root_start = (state_q == ST_SQ) & sq_res.done & ~sq_res.neg;

  brsc_isqrt u_isqrt (
    .clk_i, .rst_ni,
    .start_i (root_start),
    .rad_i   (sq_res.rad),
    .res_o   (root_res)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_FIN) & (~out_valid_q | out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = in_stop ? ST_FIN : ST_SQ;
      ST_SQ:   if (sq_res.done) state_d = sq_res.neg ? ST_FIN : ST_ROOT;
      ST_ROOT: if (root_res.done) state_d = ST_FIN;
      ST_FIN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // steering error and distance from the finished root
  always_comb begin
    pair_err = front_q ? ErrW'($signed({2'b0, fr_q}) - $signed({2'b0, fl_q}))
                       : ErrW'($signed({2'b0, bl_q}) - $signed({2'b0, br_q}));
    lim_s    = $signed({2'b0, cfg.limit});
    if (pair_err > lim_s)       clamp_err = lim_s;
    else if (pair_err < -lim_s) clamp_err = -lim_s;
    else                        clamp_err = pair_err;

    if (neg_q)                  new_dist = '0;
    else if (root_res.root[RootW-1]) new_dist = DistMax;
    else                        new_dist = root_res.root[DistW:1];

    sum_rb   = {1'b0, fr_q} + {1'b0, br_q};
    sum_lb   = {1'b0, fl_q} + {1'b0, bl_q};
    diag     = $signed({2'b0, sum_rb}) - $signed({2'b0, sum_lb});
    near_err = front_q ? diag : -diag;
    step     = band_step(new_dist);
    near_adj = near_err[DelayW+2] ? near_err + $signed({7'b0, step})
                                  : near_err - $signed({7'b0, step});
    near     = ~neg_q && (new_dist < cfg.threshold);
    new_err  = near ? near_adj[ErrW-1:0] : clamp_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      held_front_q <= 1'b1;
      held_inv_q   <= 1'b0;
      held_dist_q  <= '0;
      held_err_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      if (out_load && !stop_q) begin
        held_front_q <= front_q;
        held_inv_q   <= neg_q;
        held_dist_q  <= new_dist;
        held_err_q   <= new_err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fl_q    <= in_i.delay_front_left;
      fr_q    <= in_i.delay_front_right;
      br_q    <= in_i.delay_back_right;
      bl_q    <= in_i.delay_back_left;
      stop_q  <= in_stop;
      front_q <= in_front;
      neg_q   <= 1'b0;
    end else if (state_q == ST_SQ && sq_res.done) begin
      neg_q <= sq_res.neg;
    end
    if (out_load) begin
      out_stop_q  <= stop_q;
      out_front_q <= stop_q ? held_front_q : front_q;
      out_inv_q   <= stop_q ? held_inv_q   : neg_q;
      out_dist_q  <= stop_q ? held_dist_q  : new_dist;
      out_err_q   <= stop_q ? held_err_q   : new_err;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.stopped          = out_stop_q;
  assign out_o.heading_front    = out_front_q;
  assign out_o.distance_tenths  = out_dist_q;
  assign out_o.steer_error      = out_err_q;
  assign out_o.distance_invalid = out_inv_q;

  a_inv_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.distance_invalid |-> out_o.distance_tenths == '0)
    else $error("invalid distance reported with non-zero value");

  a_sq_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_res.done |-> state_q == ST_SQ)
    else $error("square unit finished outside its phase");

  a_root_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_res.done |-> state_q == ST_ROOT)
    else $error("root unit finished outside its phase");

  a_stop_skips_math: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_stop |=> state_q == ST_FIN)
    else $error("stopped item entered the arithmetic path");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import brsc_pkg::*;

  localparam int CycleLimit = 1_500_000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [7:0] fl;
    logic [7:0] fr;
    logic [7:0] br;
    logic [7:0] bl;
  } frame_t;

  typedef struct packed {
    logic              stopped;
    logic              front;
    logic [12:0]       dist_tenths;
    logic signed [9:0] err;
    logic              invalid;
  } steer_fix_t;

  // Range and steering predictor with its own held state and register copies.
  class steer_scoreboard;
    steer_fix_t        fix_q[$];
    int                errors;
    int unsigned       spacing;
    int unsigned       limit;
    int unsigned       threshold;
    logic              held_front;
    logic [12:0]       held_dist;
    logic signed [9:0] held_err;
    logic              held_invalid;

    function new();
      errors       = 0;
      spacing      = 200;
      limit        = 50;
      threshold    = 1000;
      held_front   = 1'b1;
      held_dist    = '0;
      held_err     = '0;
      held_invalid = 1'b0;
    endfunction

    function int unsigned floor_root(longint v);
      longint r;
      longint t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return int'(r);
    endfunction

    function int band_nudge(int unsigned d);
      if (d >= 920) return 2;
      if (d >= 860) return 3;
      if (d >= 740) return 4;
      if (d >= 590) return 5;
      if (d >= 230) return 6;
      if (d >= 60) return 7;
      return 8;
    endfunction

    function void note_frame(frame_t f);
      int          fl, fr, br, bl, i1, i2, err, diag, lim;
      bit          front, inv;
      longint      a, b, s, rad;
      int unsigned dist_tenths;
      steer_fix_t  x;
      fl = f.fl;
      fr = f.fr;
      br = f.br;
      bl = f.bl;
      if (fl != 0 || fr != 0 || br != 0 || bl != 0) begin
        front = (fl + fr) <= (br + bl);
        i1    = front ? fl : br;
        i2    = front ? fr : bl;
        lim   = int'(limit);
        err   = i2 - i1;
        if (err > lim) err = lim;
        else if (err < -lim) err = -lim;
        a     = 34 * i1;
        b     = 34 * i2;
        s     = spacing;
        rad   = 2 * a * a + 2 * b * b - s * s;
        inv   = 1'b0;
        dist_tenths = 0;
        if (rad < 0) begin
          inv = 1'b1;
        end else begin
          dist_tenths = floor_root(rad) >> 1;
          if (dist_tenths > 8191) dist_tenths = 8191;
          if (dist_tenths < threshold) begin
            diag = (fr + br) - (fl + bl);
            err  = front ? diag : -diag;
            if (err >= 0) err -= band_nudge(dist_tenths);
            else err += band_nudge(dist_tenths);
          end
        end
        if (err > 511) err = 511;
        else if (err < -512) err = -512;
        held_front   = front;
        held_dist    = dist_tenths[12:0];
        held_err     = err[9:0];
        held_invalid = inv;
      end
      x.stopped     = (fl == 0 && fr == 0 && br == 0 && bl == 0);
      x.front       = held_front;
      x.dist_tenths = held_dist;
      x.err         = held_err;
      x.invalid     = held_invalid;
      fix_q.push_back(x);
    endfunction

    function void check_result(steer_fix_t got);
      steer_fix_t want;
      if (fix_q.size() == 0) begin
        $display("%0t: result with nothing outstanding (dist %0d err %0d)",
                 $time, got.dist_tenths, $signed(got.err));
        errors++;
        return;
      end
      want = fix_q.pop_front();
      if (got.stopped !== want.stopped) begin
        $display("%0t: stopped expected %0d got %0d", $time, want.stopped, got.stopped);
        errors++;
      end
      if (got.front !== want.front) begin
        $display("%0t: heading_front expected %0d got %0d", $time, want.front, got.front);
        errors++;
      end
      if (got.dist_tenths !== want.dist_tenths) begin
        $display("%0t: distance_tenths expected %0d got %0d", $time,
                 want.dist_tenths, got.dist_tenths);
        errors++;
      end
      if (got.err !== want.err) begin
        $display("%0t: steer_error expected %0d got %0d", $time,
                 $signed(want.err), $signed(got.err));
        errors++;
      end
      if (got.invalid !== want.invalid) begin
        $display("%0t: distance_invalid expected %0d got %0d", $time,
                 want.invalid, got.invalid);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          cycles;

  brsc_in_if  in_bus ();
  brsc_out_if out_bus ();

  steer_scoreboard sb = new();

  beacon_range_steer_calc uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Extremes, equal sums, negative radicand, stop with held values, each distance band.
  frame_t directed_frames [20] = '{
    {8'd0,   8'd0,   8'd0,   8'd0},
    {8'd229, 8'd229, 8'd229, 8'd229},
    {8'd255, 8'd255, 8'd255, 8'd255},
    {8'd1,   8'd0,   8'd0,   8'd0},
    {8'd0,   8'd0,   8'd0,   8'd1},
    {8'd0,   8'd0,   8'd0,   8'd0},
    {8'd229, 8'd0,   8'd0,   8'd229},
    {8'd0,   8'd229, 8'd229, 8'd0},
    {8'd3,   8'd3,   8'd3,   8'd3},
    {8'd4,   8'd4,   8'd5,   8'd4},
    {8'd10,  8'd10,  8'd10,  8'd11},
    {8'd19,  8'd19,  8'd19,  8'd19},
    {8'd23,  8'd23,  8'd24,  8'd23},
    {8'd26,  8'd26,  8'd26,  8'd27},
    {8'd28,  8'd28,  8'd28,  8'd28},
    {8'd1,   8'd1,   8'd1,   8'd1},
    {8'd128, 8'd64,  8'd32,  8'd16},
    {8'd200, 8'd100, 8'd1,   8'd2},
    {8'd0,   8'd0,   8'd0,   8'd0},
    {8'd127, 8'd128, 8'd255, 8'd254}
  };

  function automatic logic [7:0] near_index(int base);
    int v;
    v = base + int'($urandom_range(8, 0)) - 4;
    if (v < 0) v = 0;
    if (v > 229) v = 229;
    return v[7:0];
  endfunction

  function automatic frame_t random_frame();
    int     mode, base;
    frame_t f;
    mode = $urandom_range(99, 0);
    base = $urandom_range(229, 1);
    if (mode < 8) begin
      f = '0;
    end else if (mode < 20) begin
      f = {8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
           8'($urandom_range(255, 0)), 8'($urandom_range(255, 0))};
    end else if (mode < 45) begin
      f = {8'($urandom_range(12, 0)), 8'($urandom_range(12, 0)),
           8'($urandom_range(12, 0)), 8'($urandom_range(12, 0))};
    end else if (mode < 80) begin
      f = {near_index(base), near_index(base), near_index(base), near_index(base)};
    end else begin
      f = {8'($urandom_range(229, 0)), 8'($urandom_range(229, 0)),
           8'($urandom_range(229, 0)), 8'($urandom_range(229, 0))};
    end
    return f;
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SPACING:   sb.spacing   = val[10:0];
      REG_LIMIT:     sb.limit     = val[7:0];
      REG_THRESHOLD: sb.threshold = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_registers(input int sp, input int lim, input int thr);
    while (sb.fix_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reg_write(REG_SPACING, sp);
    reg_write(REG_LIMIT, lim);
    reg_write(REG_THRESHOLD, thr);
  endtask

  task automatic send_frame(input frame_t f);
    in_bus.valid             <= 1'b1;
    in_bus.delay_front_left  <= f.fl;
    in_bus.delay_front_right <= f.fr;
    in_bus.delay_back_right  <= f.br;
    in_bus.delay_back_left   <= f.bl;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_frame(f);
  endtask

  int send_quiet = 0;

  // Drop valid for a while after a transfer, or keep offering back to back.
  task automatic pause_sender();
    int r, gap;
    gap = 0;
    if (send_quiet > 0) begin
      send_quiet--;
    end else begin
      r = $urandom_range(99, 0);
      if (r < 2) send_quiet = $urandom_range(40, 10);
      else if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(3, 1);
      else if (r < 97) gap = $urandom_range(10, 4);
      else gap = $urandom_range(60, 20);
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_frames(input int count);
    for (int n = 0; n < count; n++) begin
      send_frame(random_frame());
      pause_sender();
    end
    in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random back-pressure, one long hold-off once traffic is flowing.
  initial begin
    int  stall_left, quiet_left, seen, r;
    bit  held_off;
    steer_fix_t got;
    stall_left = 0;
    quiet_left = 0;
    seen       = 0;
    held_off   = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.stopped     = out_bus.stopped;
        got.front       = out_bus.heading_front;
        got.dist_tenths = out_bus.distance_tenths;
        got.err         = out_bus.steer_error;
        got.invalid     = out_bus.distance_invalid;
        sb.check_result(got);
        seen++;
      end
      if (!held_off && seen == 40) begin
        held_off   = 1'b1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 2) begin
          quiet_left = $urandom_range(80, 20);
          out_bus.ready <= 1'b1;
        end else if (r < 70) begin
          out_bus.ready <= 1'b1;
        end else if (r < 96) begin
          stall_left = $urandom_range(2, 0);
          out_bus.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(59, 14);
          out_bus.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n                    <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    in_bus.valid             <= 1'b0;
    in_bus.delay_front_left  <= '0;
    in_bus.delay_front_right <= '0;
    in_bus.delay_back_right  <= '0;
    in_bus.delay_back_left   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    foreach (directed_frames[k]) begin
      send_frame(directed_frames[k]);
      pause_sender();
    end
    run_frames(380);

    set_registers(2047, 0, 8191);
    run_frames(300);
    set_registers(0, 255, 0);
    run_frames(300);
    set_registers(2000, 229, 8191);
    run_frames(300);
    set_registers(1, 1, 5000);
    run_frames(300);
    set_registers($urandom_range(2047, 0), $urandom_range(255, 0), $urandom_range(8191, 0));
    run_frames(300);

    while (sb.fix_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.fix_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
